// File: hw/rtl/cdd_pkg.sv
package cdd_pkg;

	localparam int YEAR_BITS  = 12;
	localparam int DIFF_W     = 22;
	localparam int DOY_W      = 9;
	localparam int C400_W     = 9;
	localparam int MONTH_W    = 4;
	localparam int MDAY_W     = 5;
	localparam int HOUR_W     = 5;
	localparam int MINUTE_W   = 6;
	localparam int SEC_W      = 6;

	localparam int LEAP_CYCLE = 400;
	localparam int DAYS_YEAR  = 365;
	localparam int DAYS_LEAP  = 366;

	typedef enum logic [0:0] {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	// leap test on the year's position in the 400-year cycle
	function automatic logic is_leap(input logic [C400_W-1:0] c);
		return (c[1:0] == 2'b00) &&
			(c != C400_W'(100)) && (c != C400_W'(200)) && (c != C400_W'(300));
	endfunction

	// days before the first of the month, common year
	function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
		logic [DOY_W-1:0] d;
		case (m)
			4'd0:    d = DOY_W'(0);
			4'd1:    d = DOY_W'(31);
			4'd2:    d = DOY_W'(59);
			4'd3:    d = DOY_W'(90);
			4'd4:    d = DOY_W'(120);
			4'd5:    d = DOY_W'(151);
			4'd6:    d = DOY_W'(181);
			4'd7:    d = DOY_W'(212);
			4'd8:    d = DOY_W'(243);
			4'd9:    d = DOY_W'(273);
			4'd10:   d = DOY_W'(304);
			default: d = DOY_W'(334);
		endcase
		return d;
	endfunction

endpackage

// File: hw/rtl/calendar_day_difference.sv
// Throughput: one item at a time; busy stays high until the result is out, set by the
//   one-year-per-cycle accumulation loop through the shared adder.
// Reset: arst_n clears the sequencer and the done strobe asynchronously; data registers are
//   not reset. The receiver cannot stall: done is high for one cycle with the result.
module calendar_day_difference (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic        [cdd_pkg::YEAR_BITS-1:0] start_year,
	input  logic        [cdd_pkg::MONTH_W-1:0]   start_month,
	input  logic        [cdd_pkg::MDAY_W-1:0]    start_mday,
	input  logic        [cdd_pkg::HOUR_W-1:0]    start_hour,
	input  logic        [cdd_pkg::MINUTE_W-1:0]  start_minute,
	input  logic        [cdd_pkg::SEC_W-1:0]     start_sec,
	input  logic        [cdd_pkg::YEAR_BITS-1:0] end_year,
	input  logic        [cdd_pkg::MONTH_W-1:0]   end_month,
	input  logic        [cdd_pkg::MDAY_W-1:0]    end_mday,
	input  logic        [cdd_pkg::HOUR_W-1:0]    end_hour,
	input  logic        [cdd_pkg::MINUTE_W-1:0]  end_minute,
	input  logic        [cdd_pkg::SEC_W-1:0]     end_sec,
	output logic                                 done,
	output logic signed [cdd_pkg::DIFF_W-1:0]    day_difference
);

	// Sequencer:
	//   IDLE       wait for start, latch the item
	//   RED_END    end year mod 400 by repeated subtraction of 400
	//   RED_START  same for start year; on exit, seed acc with
	//              doy(end) - doy(start) - (start time later than end time)
	//   YEARS      add 365/366 per year from start year up to end year
	typedef enum logic [3:0] {
		ST_IDLE      = 4'b0001,
		ST_RED_END   = 4'b0010,
		ST_RED_START = 4'b0100,
		ST_YEARS     = 4'b1000
	} state_t;

	state_t state_q;
	logic   done_q;

	logic [cdd_pkg::YEAR_BITS-1:0] sy_q, ey_q, yr_q, rem_q;
	logic [cdd_pkg::MONTH_W-1:0]   smon_q, emon_q;
	logic [cdd_pkg::MDAY_W-1:0]    smday_q, emday_q;
	logic                          late_q;
	logic [cdd_pkg::C400_W-1:0]    end_c400_q, c400_q;
	logic [cdd_pkg::DIFF_W-1:0]    acc_q;
	logic signed [cdd_pkg::DIFF_W-1:0] result_q;

	logic                        accept;
	logic                        time_late;
	logic [cdd_pkg::DIFF_W-1:0]  rem_ext;
	logic [cdd_pkg::C400_W-1:0]  rem_c400;
	logic                        more_years;

	cdd_pkg::alu_op_t            alu_op;
	logic [cdd_pkg::DIFF_W-1:0]  alu_a, alu_b, alu_res;
	logic                        alu_ge;

	logic [cdd_pkg::DOY_W-1:0]   doy_s, doy_e;

	assign accept     = start && !busy;
	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign day_difference = result_q;

	// lexicographic compare of (hour, minute, second)
	assign time_late  = {start_hour, start_minute, start_sec} > {end_hour, end_minute, end_sec};

	assign rem_ext    = cdd_pkg::DIFF_W'(rem_q);
	assign rem_c400   = rem_ext[cdd_pkg::C400_W-1:0];
	assign more_years = (yr_q < ey_q);

	// shared unit: subtract 400 while reducing, accumulate year lengths otherwise
	always_comb begin
		case (state_q)
			ST_RED_END, ST_RED_START: begin
				alu_op = cdd_pkg::ALU_SUB;
				alu_a  = rem_ext;
				alu_b  = cdd_pkg::DIFF_W'(cdd_pkg::LEAP_CYCLE);
			end
			default: begin
				alu_op = cdd_pkg::ALU_ADD;
				alu_a  = acc_q;
				alu_b  = cdd_pkg::is_leap(c400_q) ? cdd_pkg::DIFF_W'(cdd_pkg::DAYS_LEAP)
					: cdd_pkg::DIFF_W'(cdd_pkg::DAYS_YEAR);
			end
		endcase
	end

	cdd_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res),
		.ge  (alu_ge)
	);

	// start leap flag is only meaningful on the RED_START exit cycle (rem_q < 400)
	cdd_doy u_doy_start (
		.month (smon_q),
		.mday  (smday_q),
		.leap  (cdd_pkg::is_leap(rem_c400)),
		.doy   (doy_s)
	);

	cdd_doy u_doy_end (
		.month (emon_q),
		.mday  (emday_q),
		.leap  (cdd_pkg::is_leap(end_c400_q)),
		.doy   (doy_e)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_RED_END;
				end
				ST_RED_END: begin
					if (!alu_ge) state_q <= ST_RED_START;
				end
				ST_RED_START: begin
					if (!alu_ge) state_q <= ST_YEARS;
				end
				ST_YEARS: begin
					if (!more_years) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					sy_q    <= start_year;
					ey_q    <= end_year;
					smon_q  <= start_month;
					emon_q  <= end_month;
					smday_q <= start_mday;
					emday_q <= end_mday;
					late_q  <= time_late;
					rem_q   <= end_year;
				end
			end
			ST_RED_END: begin
				if (alu_ge) begin
					rem_q <= alu_res[cdd_pkg::YEAR_BITS-1:0];
				end else begin
					end_c400_q <= rem_c400;
					rem_q      <= sy_q;
				end
			end
			ST_RED_START: begin
				if (alu_ge) begin
					rem_q <= alu_res[cdd_pkg::YEAR_BITS-1:0];
				end else begin
					c400_q <= rem_c400;
					yr_q   <= sy_q;
					acc_q  <= cdd_pkg::DIFF_W'(doy_e) - cdd_pkg::DIFF_W'(doy_s)
						- cdd_pkg::DIFF_W'(late_q);
				end
			end
			ST_YEARS: begin
				if (more_years) begin
					acc_q  <= alu_res;
					yr_q   <= yr_q + 1'b1;
					c400_q <= (c400_q == cdd_pkg::C400_W'(cdd_pkg::LEAP_CYCLE - 1))
						? '0 : c400_q + 1'b1;
				end else begin
					result_q <= acc_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/cdd_alu.sv
module cdd_alu (
	input  cdd_pkg::alu_op_t             op,
	input  logic [cdd_pkg::DIFF_W-1:0]   a,
	input  logic [cdd_pkg::DIFF_W-1:0]   b,
	output logic [cdd_pkg::DIFF_W-1:0]   res,
	output logic                         ge
);

	// shared add/sub; ge is the unsigned a >= b flag
	always_comb begin
		case (op)
			cdd_pkg::ALU_SUB: res = a - b;
			default:          res = a + b;
		endcase
	end

	assign ge = (a >= b);

endmodule

// File: hw/rtl/cdd_doy.sv
module cdd_doy (
	input  logic [cdd_pkg::MONTH_W-1:0] month,
	input  logic [cdd_pkg::MDAY_W-1:0]  mday,
	input  logic                        leap,
	output logic [cdd_pkg::DOY_W-1:0]   doy
);

	logic [cdd_pkg::MONTH_W-1:0] m_sat;
	logic                        feb_extra;

	// month codes past December count as December
	assign m_sat     = (month > cdd_pkg::MONTH_W'(11)) ? cdd_pkg::MONTH_W'(11) : month;
	assign feb_extra = leap && (m_sat >= cdd_pkg::MONTH_W'(2));
	assign doy       = cdd_pkg::days_before(m_sat) + cdd_pkg::DOY_W'(feb_extra)
		+ cdd_pkg::DOY_W'(mday);

endmodule

// File: hw/rtl/cdd_checker.sv
module cdd_props (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// accepted item makes the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted item");

	// result only while not busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done longer than one cycle");

	// busy drops exactly when the result appears
	a_fall_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without result");

endmodule

bind calendar_day_difference cdd_props u_cdd_props (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
